// ===== src/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

  localparam int RGB_W = 8;
  localparam int HUE_W = 15;
  localparam int PCT_W = 13;

  // long-division datapath: numerators, doubled divisors, quotients
  localparam int NUM_W = 24;
  localparam int DEN_W = 9;
  localparam int QUO_W = 15;

  // degrees and percent carry 6 fraction bits
  localparam int HUE_FULL   = 360 * 64;
  localparam int HUE_SCALE  = 2 * 60 * 64;
  localparam int PCT_SCALE  = 2 * 100 * 64;
  localparam int VAL_MAX    = 255;

  // value numerator over 2*255: multiply by ceil(2^31 / 510), keep bits from 31 up
  localparam int VPROD_W    = 48;
  localparam int VAL_RECIP  = 4210753;
  localparam int VAL_SHIFT  = 31;

  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  typedef struct packed {
    logic [NUM_W-1:0] hue_num;
    logic [DEN_W-1:0] hue_den;
    logic [NUM_W-1:0] sat_num;
    logic [DEN_W-1:0] sat_den;
    logic [NUM_W-1:0] val_num;
    logic             gray;
  } front_t;

endpackage

// ===== src/rgbhsv_ifs.sv =====
interface rgbhsv_pix_if;
  logic                          valid;
  logic                          ready;
  logic [rgbhsv_pkg::RGB_W-1:0]  red;
  logic [rgbhsv_pkg::RGB_W-1:0]  green;
  logic [rgbhsv_pkg::RGB_W-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_hsv_if;
  logic                          valid;
  logic                          ready;
  logic [rgbhsv_pkg::HUE_W-1:0]  hue;
  logic [rgbhsv_pkg::PCT_W-1:0]  saturation;
  logic [rgbhsv_pkg::PCT_W-1:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// ===== src/rgb_to_hsv.sv =====
// Pipeline from an accepted input transaction to its result on out_hsv: two front
//   stages, one long-division stage per quotient bit, then the output register.
// Throughput: one pixel per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n, synchronous, active low) clears the valid bits only; data
//   registers are not reset.
module rgb_to_hsv (
  input  logic                clk,
  input  logic                rst_n,
  rgbhsv_pix_if.sink          in_pix,
  rgbhsv_hsv_if.source        out_hsv
);

  localparam int STG_N = 2 + rgbhsv_pkg::QUO_W;
  localparam int QW    = rgbhsv_pkg::QUO_W;

  logic                         en;
  logic                         in_fire;
  logic [STG_N-1:0]             vld_r, vld_nxt;
  logic [QW-1:0]                gray_r, gray_nxt;
  rgbhsv_pkg::front_t           front;
  logic [QW-1:0]                hue_q, sat_q;
  logic [rgbhsv_pkg::VPROD_W-1:0]          val_prod;
  logic [QW-1:0][rgbhsv_pkg::PCT_W-1:0]    val_dly_r, val_dly_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [rgbhsv_pkg::HUE_W-1:0] hue_r, hue_nxt;
  logic [rgbhsv_pkg::PCT_W-1:0] sat_r, sat_nxt;
  logic [rgbhsv_pkg::PCT_W-1:0] val_r, val_nxt;

  // advance everything unless a finished result is held by the sink
  assign en      = ~out_valid_r | out_hsv.ready;
  assign in_fire = in_pix.valid & en & rst_n;
  assign in_pix.ready = en & rst_n;

  rgbhsv_front u_front (
    .clk   (clk),
    .en    (en),
    .red   (in_pix.red),
    .green (in_pix.green),
    .blue  (in_pix.blue),
    .front (front)
  );

  rgbhsv_div u_div_hue (
    .clk  (clk),
    .en   (en),
    .num  (front.hue_num),
    .den  (front.hue_den),
    .quot (hue_q)
  );

  rgbhsv_div u_div_sat (
    .clk  (clk),
    .en   (en),
    .num  (front.sat_num),
    .den  (front.sat_den),
    .quot (sat_q)
  );

  // value divides by a constant: multiply by the scaled reciprocal, then
  // carry it alongside the divider stages
  assign val_prod    = rgbhsv_pkg::VPROD_W'(front.val_num) *
                       rgbhsv_pkg::VPROD_W'(rgbhsv_pkg::VAL_RECIP);
  assign val_dly_nxt = {val_dly_r[QW-2:0],
                        val_prod[rgbhsv_pkg::VAL_SHIFT +: rgbhsv_pkg::PCT_W]};

  assign vld_nxt  = {vld_r[STG_N-2:0], in_fire};
  assign gray_nxt = {gray_r[QW-2:0], front.gray};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gray_r    <= gray_nxt;
      val_dly_r <= val_dly_nxt;
    end
  end

  // final stage: wrap a hue that rounds to a full turn, zero hue and saturation of gray pixels
  always_comb begin
    out_valid_nxt = vld_r[STG_N-1];
    if (gray_r[QW-1]) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      if (hue_q >= QW'(rgbhsv_pkg::HUE_FULL)) begin
        hue_nxt = rgbhsv_pkg::HUE_W'(hue_q - QW'(rgbhsv_pkg::HUE_FULL));
      end else begin
        hue_nxt = rgbhsv_pkg::HUE_W'(hue_q);
      end
      sat_nxt = sat_q[rgbhsv_pkg::PCT_W-1:0];
    end
    val_nxt = val_dly_r[QW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      val_r <= val_nxt;
    end
  end

  assign out_hsv.valid      = out_valid_r;
  assign out_hsv.hue        = hue_r;
  assign out_hsv.saturation = sat_r;
  assign out_hsv.brightness = val_r;

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (hue_r < rgbhsv_pkg::HUE_W'(rgbhsv_pkg::HUE_FULL)))
    else $error("hue out of range");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (sat_r <= rgbhsv_pkg::PCT_W'(rgbhsv_pkg::PCT_SCALE / 2) &&
                     val_r <= rgbhsv_pkg::PCT_W'(rgbhsv_pkg::PCT_SCALE / 2)))
    else $error("percent out of range");

  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sat_r == '0) |-> (hue_r == '0))
    else $error("zero saturation with nonzero hue");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && $stable(gray_r))
    else $error("pipeline moved during stall");

endmodule

// ===== src/rgbhsv_front.sv =====
module rgbhsv_front (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rgbhsv_pkg::RGB_W-1:0] red,
  input  logic [rgbhsv_pkg::RGB_W-1:0] green,
  input  logic [rgbhsv_pkg::RGB_W-1:0] blue,
  output rgbhsv_pkg::front_t           front
);

  logic [rgbhsv_pkg::RGB_W-1:0] hi_nxt, lo_nxt, hi_r, lo_r;
  logic [1:0]                   sec_nxt, sec_r;
  logic signed [rgbhsv_pkg::RGB_W:0] diff_nxt, diff_r;

  logic [rgbhsv_pkg::RGB_W-1:0] d;
  logic signed [11:0]           off, t_raw, t_fix;
  rgbhsv_pkg::front_t           front_nxt, front_r;

  // stage 1: extremes and the sector of the maximum
  always_comb begin
    hi_nxt = red;
    lo_nxt = red;
    if (green > hi_nxt) hi_nxt = green;
    if (blue > hi_nxt)  hi_nxt = blue;
    if (green < lo_nxt) lo_nxt = green;
    if (blue < lo_nxt)  lo_nxt = blue;
    if (red == hi_nxt) begin
      sec_nxt  = rgbhsv_pkg::SEC_RED;
      diff_nxt = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green == hi_nxt) begin
      sec_nxt  = rgbhsv_pkg::SEC_GREEN;
      diff_nxt = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sec_nxt  = rgbhsv_pkg::SEC_BLUE;
      diff_nxt = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r   <= hi_nxt;
      lo_r   <= lo_nxt;
      sec_r  <= sec_nxt;
      diff_r <= diff_nxt;
    end
  end

  // stage 2: hue in sextants times delta, then the divider operands
  always_comb begin
    d = hi_r - lo_r;
    case (sec_r)
      rgbhsv_pkg::SEC_GREEN: off = $signed({3'b000, d, 1'b0});
      rgbhsv_pkg::SEC_BLUE:  off = $signed({2'b00, d, 2'b00});
      default:               off = '0;
    endcase
    t_raw = off + 12'(diff_r);
    // wrap negative hue by a full turn of six sextants
    if (t_raw < 0) t_fix = t_raw + $signed({2'b00, d, 2'b00}) + $signed({3'b000, d, 1'b0});
    else           t_fix = t_raw;

    front_nxt.hue_num = rgbhsv_pkg::NUM_W'(
                          rgbhsv_pkg::NUM_W'(t_fix[10:0]) *
                          rgbhsv_pkg::NUM_W'(rgbhsv_pkg::HUE_SCALE) +
                          rgbhsv_pkg::NUM_W'(d));
    front_nxt.hue_den = {d, 1'b0};
    front_nxt.sat_num = rgbhsv_pkg::NUM_W'(
                          rgbhsv_pkg::NUM_W'(d) *
                          rgbhsv_pkg::NUM_W'(rgbhsv_pkg::PCT_SCALE) +
                          rgbhsv_pkg::NUM_W'(hi_r));
    front_nxt.sat_den = {hi_r, 1'b0};
    front_nxt.val_num = rgbhsv_pkg::NUM_W'(
                          rgbhsv_pkg::NUM_W'(hi_r) *
                          rgbhsv_pkg::NUM_W'(rgbhsv_pkg::PCT_SCALE) +
                          rgbhsv_pkg::NUM_W'(rgbhsv_pkg::VAL_MAX));
    front_nxt.gray    = (d == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_r <= front_nxt;
    end
  end

  assign front = front_r;

endmodule

// ===== src/rgbhsv_div.sv =====
module rgbhsv_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rgbhsv_pkg::NUM_W-1:0] num,
  input  logic [rgbhsv_pkg::DEN_W-1:0] den,
  output logic [rgbhsv_pkg::QUO_W-1:0] quot
);

  localparam int NW = rgbhsv_pkg::NUM_W;
  localparam int DW = rgbhsv_pkg::DEN_W;
  localparam int QW = rgbhsv_pkg::QUO_W;

  // one quotient bit per stage, most significant first
  logic [NW-1:0] rem_r [QW-1];
  logic [DW-1:0] den_r [QW-1];
  logic [QW-1:0] quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [NW:0]   trial;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = {1'b0, rem_in} - ((NW+1)'(den_in) << SH);

    always_comb begin
      quo_nxt     = quo_in;
      quo_nxt[SH] = ~trial[NW];
      rem_nxt     = trial[NW] ? rem_in : trial[NW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= quo_nxt;
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quot = quo_r[QW-1];

endmodule
